// ===== hdl/sac_pkg.sv =====
// Shared constants, defaults and state types of the set-associative cache tag model.
package sac_pkg;

  // Fixed widths of the channel words.
  localparam int ADDRESS_W = 48;
  localparam int WAY_W     = 2;

  // Default geometry.
  localparam int SETS_DEFAULT        = 64;
  localparam int WAYS_DEFAULT        = 4;
  localparam int BLOCK_BYTES_DEFAULT = 64;
  localparam int ADDR_BITS_DEFAULT   = 48;

  // Depth of the queue between the address splitter and the lookup engine.
  localparam int QUEUE_DEPTH = 2;

  // Address splitter sequencer, used when the geometry is not a power of two.
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV_TAG,
    FE_DIV_SET,
    FE_PUSH
  } fe_state_t;

  // Lookup engine sequencer.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP
  } bk_state_t;

endpackage

// ===== hdl/sac_if.sv =====
// Handshake interfaces for the address, result and internal queue channels.
interface sac_addr_if;
  import sac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDRESS_W-1:0] address;

  modport source (output valid, address, input ready);
  modport sink   (input valid, address, output ready);
endinterface

interface sac_result_if;
  import sac_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] way;
  logic             evicted;

  modport source (output valid, hit, way, evicted, input ready);
  modport sink   (input valid, hit, way, evicted, output ready);
endinterface

interface sac_item_if #(
  parameter int WIDTH = 8
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/set_assoc_cache_lru.sv =====
// Top level of the set-associative cache tag model with true LRU replacement.
//
//   channel   direction  word                          handshake
//   access    in         address[47:0]                 valid / ready
//   result    out        hit, way[1:0], evicted        valid / ready
//
// The lookup engine handles one word at a time: it first reads the set row
// from the tag and state RAMs, then compares, ages and writes back.
// With power-of-two geometry the splitter passes one word a cycle, while the
// queue has room, into a 2-entry queue; otherwise it takes one word at a time
// through the accept step, four multiply-accumulate steps for the tag, two
// steps for the set index and one hand-off step. After reset a clearing pass
// over every set zeroes the valid bits and ages; access.ready stays low during it.
// A stalled result sits in the output register while the splitter and queue
// keep taking words until the queue is full.
module set_assoc_cache_lru #(
  parameter int SETS        = sac_pkg::SETS_DEFAULT,
  parameter int WAYS        = sac_pkg::WAYS_DEFAULT,
  parameter int BLOCK_BYTES = sac_pkg::BLOCK_BYTES_DEFAULT,
  parameter int ADDR_BITS   = sac_pkg::ADDR_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  sac_addr_if.sink     access,
  sac_result_if.source result
);

  import sac_pkg::*;

  localparam int    AW       = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int    SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam longint MAX_TAG = ((longint'(1) << AW) - 1) / (BLOCK_BYTES * SETS);
  localparam int    TAG_BITS = (MAX_TAG > 0) ? $clog2(MAX_TAG + 1) : 1;
  localparam int    ITEM_W   = TAG_BITS + SET_BITS;

  logic clearing;

  sac_item_if #(.WIDTH(ITEM_W)) fe_item ();
  sac_item_if #(.WIDTH(ITEM_W)) bk_item ();

  sac_front #(
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .hold   (clearing),
    .access (access),
    .item   (fe_item)
  );

  sac_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (fe_item),
    .pop  (bk_item)
  );

  sac_back #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .item     (bk_item),
    .result   (result)
  );

  // No address word is taken while the clearing pass runs.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !access.ready)
    else $error("address word accepted during the clearing pass");

  // A hit never reports an eviction.
  a_hit_not_evicted: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.hit |-> !result.evicted)
    else $error("hit reported together with an eviction");

  // Reset leaves no result pending.
  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result still valid after reset");

endmodule

// ===== hdl/sac_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sac_fifo.sv =====
// Short word queue that decouples the address splitter from the lookup engine.
module sac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  sac_item_if.sink   push,
  sac_item_if.source pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push.ready = (count != CNT_W'(DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.data   = mem[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  // Storage of queued words.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/sac_front.sv =====
// Address splitter: accepts address words and forms the set index and tag.
module sac_front #(
  parameter int SETS        = sac_pkg::SETS_DEFAULT,
  parameter int BLOCK_BYTES = sac_pkg::BLOCK_BYTES_DEFAULT,
  parameter int ADDR_BITS   = sac_pkg::ADDR_BITS_DEFAULT,
  parameter int TAG_BITS    = 36
) (
  input  logic clk,
  input  logic rst,
  input  logic hold,
  sac_addr_if.sink   access,
  sac_item_if.source item
);

  import sac_pkg::*;

  localparam int AW       = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int DIV_TAG  = BLOCK_BYTES * SETS;
  localparam bit POW2     = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0) &&
                            ((SETS & (SETS - 1)) == 0);

  logic [AW-1:0] addr_m;

  // Bits at or above the address width are ignored.
  assign addr_m = access.address[AW-1:0];

  if (POW2) begin : g_shift
    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int SHIFT    = OFF_BITS + $clog2(SETS);

    logic [SET_BITS-1:0] set_idx;
    logic [TAG_BITS-1:0] tag;

    // Power-of-two geometry: the split is a pair of shifts and a mask.
    assign set_idx = SET_BITS'((addr_m >> OFF_BITS) & AW'(SETS - 1));
    assign tag     = TAG_BITS'(addr_m >> SHIFT);

    assign item.valid   = access.valid && !hold;
    assign item.data    = {tag, set_idx};
    assign access.ready = item.ready && !hold;

  end else begin : g_divide
    // Division by a constant as a multiplication by a rounded-up reciprocal:
    // floor(x * M / 2**S) equals floor(x / d) for every x below 2**N when
    // S = N + clog2(d) and M = ceil(2**S / d).
    localparam int XW    = 48;
    localparam int XH    = XW / 2;
    localparam int MW    = XW + 2;
    localparam int MH    = MW / 2;
    localparam int ACC_W = XW + MW;
    localparam int RW    = $clog2(DIV_TAG);
    localparam int S_TAG = AW + RW;
    localparam int S_SET = RW + $clog2(BLOCK_BYTES);
    localparam int MS_W  = RW + 2;
    localparam logic [127:0] D_TAG_W = 128'(DIV_TAG);
    localparam logic [127:0] D_SET_W = 128'(BLOCK_BYTES);
    localparam logic [MW-1:0] M_TAG =
      MW'(((128'd1 << S_TAG) + D_TAG_W - 128'd1) / D_TAG_W);
    localparam logic [MS_W-1:0] M_SET =
      MS_W'(((128'd1 << S_SET) + D_SET_W - 128'd1) / D_SET_W);

    fe_state_t            state;
    fe_state_t            state_next;
    logic [XW-1:0]        x_r;
    logic [ACC_W-1:0]     acc;
    logic [ACC_W-1:0]     acc_next;
    logic [XH-1:0]        x_part;
    logic [MH-1:0]        m_part;
    logic [XH+MH-1:0]     pp;
    logic [ACC_W-1:0]     pp_sh;
    logic [RW-1:0]        rem_r;
    logic [RW-1:0]        rem_next;
    logic [RW+MS_W-1:0]   set_prod;
    logic [1:0]           step;
    logic                 last_step;
    logic [TAG_BITS-1:0]  tag_r;
    logic [SET_BITS-1:0]  set_r;
    logic                 accept;

    assign accept    = access.valid && access.ready;
    assign last_step = (state == FE_DIV_TAG) ? (step == 2'd3) : (step == 2'd1);

    // One partial product of the tag reciprocal per cycle: low and high halves
    // of the address against low and high halves of the constant.
    assign x_part = step[1] ? x_r[XW-1:XH] : x_r[XH-1:0];
    assign m_part = step[0] ? M_TAG[MW-1:MH] : M_TAG[MH-1:0];
    assign pp     = x_part * m_part;

    always_comb begin
      case (step)
        2'd0:    pp_sh = ACC_W'(pp);
        2'd1:    pp_sh = ACC_W'(pp) << MH;
        2'd2:    pp_sh = ACC_W'(pp) << XH;
        default: pp_sh = ACC_W'(pp) << (XH + MH);
      endcase
    end

    assign acc_next = acc + pp_sh;

    // The remainder by the set span fits in RW bits, so only the low bits of
    // the tag take part; the set index is that remainder over the block size.
    assign rem_next = RW'(x_r) - RW'(tag_r) * RW'(DIV_TAG);
    assign set_prod = rem_r * M_SET;

    // Next state.
    always_comb begin
      state_next = state;
      case (state)
        FE_IDLE:    if (accept) state_next = FE_DIV_TAG;
        FE_DIV_TAG: if (last_step) state_next = FE_DIV_SET;
        FE_DIV_SET: if (last_step) state_next = FE_PUSH;
        FE_PUSH:    if (item.ready) state_next = FE_IDLE;
        default:    state_next = FE_IDLE;
      endcase
    end

    // Sequencer outputs.
    always_comb begin
      access.ready = 1'b0;
      item.valid   = 1'b0;
      case (state)
        FE_IDLE:  access.ready = !hold;
        FE_PUSH:  item.valid = 1'b1;
        default:  access.ready = 1'b0;
      endcase
    end

    assign item.data = {tag_r, set_r};

    always_ff @(posedge clk) begin
      if (rst) begin
        state <= FE_IDLE;
      end else begin
        state <= state_next;
      end
    end

    // Step counter within the tag and set phases.
    always_ff @(posedge clk) begin
      if (rst) begin
        step <= '0;
      end else if (state == FE_DIV_TAG || state == FE_DIV_SET) begin
        step <= last_step ? '0 : step + 1'b1;
      end
    end

    // Operand capture, tag accumulation, remainder and set index.
    always_ff @(posedge clk) begin
      if (accept) begin
        x_r <= XW'(addr_m);
        acc <= '0;
      end else if (state == FE_DIV_TAG) begin
        acc <= acc_next;
        if (last_step) begin
          tag_r <= TAG_BITS'(acc_next >> S_TAG);
        end
      end else if (state == FE_DIV_SET) begin
        if (step == 2'd0) begin
          rem_r <= rem_next;
        end else begin
          set_r <= SET_BITS'(set_prod >> S_SET);
        end
      end
    end
  end

endmodule

// ===== hdl/sac_back.sv =====
// Lookup engine: reads a set row, matches tags, picks a way, ages the set and writes back.
module sac_back #(
  parameter int SETS     = sac_pkg::SETS_DEFAULT,
  parameter int WAYS     = sac_pkg::WAYS_DEFAULT,
  parameter int TAG_BITS = 36
) (
  input  logic clk,
  input  logic rst,
  output logic clearing,
  sac_item_if.sink     item,
  sac_result_if.source result
);

  import sac_pkg::*;

  localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_BITS  = WAY_BITS;
  localparam int ST_W      = WAYS + WAYS * AGE_BITS;
  localparam int TAG_ROW_W = WAYS * TAG_BITS;

  bk_state_t            state;
  bk_state_t            state_next;
  logic [SET_BITS-1:0]  clr_cnt;
  logic [SET_BITS-1:0]  set_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic                 res_valid;
  logic                 res_hit;
  logic [WAY_W-1:0]     res_way;
  logic                 res_evicted;

  // RAM ports.
  logic                 rd_en;
  logic                 st_we;
  logic [SET_BITS-1:0]  st_waddr;
  logic [ST_W-1:0]      st_wdata;
  logic [ST_W-1:0]      st_rd;
  logic                 tag_we;
  logic [TAG_ROW_W-1:0] tag_rd;
  logic [TAG_ROW_W-1:0] tag_wr;
  logic                 commit;

  // Lookup results.
  logic [WAYS-1:0]      valid_v;
  logic [AGE_BITS-1:0]  age_a [WAYS];
  logic [WAYS-1:0]      match;
  logic [WAYS-1:0]      is_max;
  logic                 hit_any;
  logic                 inv_any;
  logic [WAY_BITS-1:0]  hit_idx;
  logic [WAY_BITS-1:0]  inv_idx;
  logic [WAY_BITS-1:0]  vic_idx;
  logic [WAY_BITS-1:0]  way_sel;
  logic [AGE_BITS-1:0]  old_age;
  logic [ST_W-1:0]      st_new;

  // Valid bits and ages share one row per set; the tags have a row of their own.
  sac_ram #(.WIDTH(ST_W), .DEPTH(SETS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (item.data[SET_BITS-1:0]),
    .rdata (st_rd)
  );

  sac_ram #(.WIDTH(TAG_ROW_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_r),
    .wdata (tag_wr),
    .re    (rd_en),
    .raddr (item.data[SET_BITS-1:0]),
    .rdata (tag_rd)
  );

  // Tag match, lowest invalid way and oldest way, all ways in parallel.
  always_comb begin
    valid_v = st_rd[WAYS-1:0];
    match   = '0;
    is_max  = '0;
    for (int w = 0; w < WAYS; w++) begin
      age_a[w] = st_rd[WAYS + w * AGE_BITS +: AGE_BITS];
      match[w] = valid_v[w] && (tag_rd[w * TAG_BITS +: TAG_BITS] == tag_r);
    end
    // A way is the victim when it is the first of the greatest ages.
    for (int w = 0; w < WAYS; w++) begin
      is_max[w] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (j < w && age_a[j] >= age_a[w]) is_max[w] = 1'b0;
        if (j > w && age_a[j] > age_a[w]) is_max[w] = 1'b0;
      end
    end
    hit_any = |match;
    inv_any = ~&valid_v;
    hit_idx = '0;
    inv_idx = '0;
    vic_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_idx = WAY_BITS'(w);
      if (!valid_v[w]) inv_idx = WAY_BITS'(w);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (is_max[w]) vic_idx = vic_idx | WAY_BITS'(w);
    end
  end

  // Chosen way, new ages and the rewritten tag row.
  always_comb begin
    if (hit_any) begin
      way_sel = hit_idx;
    end else if (inv_any) begin
      way_sel = inv_idx;
    end else begin
      way_sel = vic_idx;
    end
    old_age = age_a[way_sel];
    st_new  = st_rd;
    tag_wr  = tag_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_BITS'(w) == way_sel) begin
        st_new[w] = 1'b1;
        st_new[WAYS + w * AGE_BITS +: AGE_BITS] = '0;
        tag_wr[w * TAG_BITS +: TAG_BITS] = tag_r;
      end else if (valid_v[w]) begin
        if (hit_any ? (age_a[w] < old_age) : (age_a[w] < AGE_BITS'(WAYS - 1))) begin
          st_new[WAYS + w * AGE_BITS +: AGE_BITS] = age_a[w] + 1'b1;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR:  if (clr_cnt == SET_BITS'(SETS - 1)) state_next = BK_IDLE;
      BK_IDLE:   if (item.valid) state_next = BK_LOOKUP;
      BK_LOOKUP: if (!res_valid || result.ready) state_next = BK_IDLE;
      default:   state_next = BK_CLEAR;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    clearing   = 1'b0;
    item.ready = 1'b0;
    rd_en      = 1'b0;
    commit     = 1'b0;
    st_we      = 1'b0;
    st_waddr   = set_r;
    st_wdata   = st_new;
    case (state)
      BK_CLEAR: begin
        clearing = 1'b1;
        st_we    = 1'b1;
        st_waddr = clr_cnt;
        st_wdata = '0;
      end
      BK_IDLE: begin
        item.ready = 1'b1;
        rd_en      = item.valid;
      end
      BK_LOOKUP: begin
        commit = !res_valid || result.ready;
        st_we  = commit;
      end
      default: clearing = 1'b0;
    endcase
  end

  assign tag_we = commit && !hit_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Hold the word being looked up.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      set_r <= item.data[SET_BITS-1:0];
      tag_r <= item.data[SET_BITS +: TAG_BITS];
    end
  end

  // Output register; a new result loads when the slot is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_hit     <= hit_any;
      res_way     <= WAY_W'(way_sel);
      res_evicted <= !hit_any && !inv_any;
    end
  end

  assign result.valid   = res_valid;
  assign result.hit     = res_hit;
  assign result.way     = res_way;
  assign result.evicted = res_evicted;

endmodule

// ===== sim/set_assoc_cache_lru_tb.sv =====
// Self-checking testbench of the set-associative cache tag model with true LRU replacement.
module set_assoc_cache_lru_tb;
  import sac_pkg::*;

  // Geometry of the instance under test.
  localparam int N_SETS         = SETS_DEFAULT;
  localparam int N_WAYS         = WAYS_DEFAULT;
  localparam int LINE_BYTES     = BLOCK_BYTES_DEFAULT;
  localparam int ADDR_BITS_USED = ADDR_BITS_DEFAULT;
  localparam int TAG_W          = ADDR_BITS_USED - $clog2(N_SETS) - $clog2(LINE_BYTES);
  localparam longint unsigned TAG_MAX = (64'd1 << TAG_W) - 1;

  localparam int RANDOM_WORDS = 750;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 250;
  localparam int HOLD_AT      = 420;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted;
  } outcome_t;

  // One directed word; typed rows carry an expectation written by hand.
  typedef struct packed {
    logic [ADDRESS_W-1:0] address;
    logic                 typed;
    outcome_t             want;
  } probe_t;

  logic clk = 1'b0;
  logic rst;

  sac_addr_if   access_bus ();
  sac_result_if result_bus ();

  set_assoc_cache_lru DUT (
    .clk    (clk),
    .rst    (rst),
    .access (access_bus),
    .result (result_bus)
  );

  always #1 clk = ~clk;

  // Predicted contents of every set: valid bit, tag and LRU age per way.
  bit              line_valid [N_SETS][N_WAYS];
  longint unsigned line_tag   [N_SETS][N_WAYS];
  int              line_age   [N_SETS][N_WAYS];

  outcome_t        pending_results [$];
  longint unsigned tag_pool [8];
  int              mismatch_count = 0;
  bit              quiet = 1'b0;
  bit              hold_request = 1'b0;

  // Directed words: empty cache, offset and tag extremes, filling a set, LRU eviction,
  // hit ageing, then a few bit patterns.
  probe_t directed_rows [20] = '{
    '{48'h0000_0000_0000, 1'b1, '{1'b0, 2'd0, 1'b0}},
    '{48'h0000_0000_0000, 1'b1, '{1'b1, 2'd0, 1'b0}},
    '{48'h0000_0000_003F, 1'b1, '{1'b1, 2'd0, 1'b0}},
    '{48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 2'd0, 1'b0}},
    '{48'h0000_0000_0FC0, 1'b1, '{1'b0, 2'd1, 1'b0}},
    '{48'h0000_0000_1000, 1'b1, '{1'b0, 2'd1, 1'b0}},
    '{48'h0000_0000_2000, 1'b1, '{1'b0, 2'd2, 1'b0}},
    '{48'h0000_0000_3000, 1'b1, '{1'b0, 2'd3, 1'b0}},
    '{48'h0000_0000_4000, 1'b1, '{1'b0, 2'd0, 1'b1}},
    '{48'h0000_0000_1010, 1'b0, '0},
    '{48'h0000_0000_5000, 1'b0, '0},
    '{48'h0000_0000_0000, 1'b0, '0},
    '{48'hFFFF_FFFF_F03F, 1'b0, '0},
    '{48'hFFFF_FFFF_FFC0, 1'b0, '0},
    '{48'h8000_0000_0000, 1'b0, '0},
    '{48'h0000_0000_0040, 1'b0, '0},
    '{48'h0000_0000_1040, 1'b0, '0},
    '{48'h0000_0000_0FFF, 1'b0, '0},
    '{48'h5555_5555_5555, 1'b0, '0},
    '{48'hAAAA_AAAA_AAAA, 1'b0, '0}
  };

  // Looks up one address, updates the predicted set and returns the outcome.
  function automatic outcome_t lookup_and_age(input logic [ADDRESS_W-1:0] a);
    longint unsigned addr, blk, tag;
    int       set_idx, way_idx, oldest, prior_age;
    bit       hit_flag, evict_flag, placed;
    outcome_t o;
    addr = 64'(a);
    if (ADDR_BITS_USED < 64) begin
      addr = addr & ((64'd1 << ADDR_BITS_USED) - 1);
    end
    blk        = addr / LINE_BYTES;
    set_idx    = int'(blk % N_SETS);
    tag        = blk / N_SETS;
    hit_flag   = 1'b0;
    evict_flag = 1'b0;
    placed     = 1'b0;
    way_idx    = 0;
    for (int w = 0; w < N_WAYS; w++) begin
      if (!hit_flag && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        hit_flag = 1'b1;
        way_idx  = w;
      end
    end
    // On a miss, take the first empty way, else the oldest one (lowest way on a tie).
    if (!hit_flag) begin
      for (int w = 0; w < N_WAYS; w++) begin
        if (!placed && !line_valid[set_idx][w]) begin
          placed  = 1'b1;
          way_idx = w;
        end
      end
      if (!placed) begin
        oldest = 0;
        for (int w = 0; w < N_WAYS; w++) begin
          if (line_age[set_idx][w] > oldest) begin
            oldest  = line_age[set_idx][w];
            way_idx = w;
          end
        end
        evict_flag = 1'b1;
      end
      line_valid[set_idx][way_idx] = 1'b1;
      line_tag[set_idx][way_idx]   = tag;
    end
    // A hit ages only the younger ways; a fill ages all other valid ways, saturating.
    prior_age = line_age[set_idx][way_idx];
    for (int w = 0; w < N_WAYS; w++) begin
      if (w != way_idx && line_valid[set_idx][w]) begin
        if (hit_flag) begin
          if (line_age[set_idx][w] < prior_age) line_age[set_idx][w]++;
        end else if (line_age[set_idx][w] < N_WAYS - 1) begin
          line_age[set_idx][w]++;
        end
      end
    end
    line_age[set_idx][way_idx] = 0;
    o.hit     = hit_flag;
    o.way     = way_idx[WAY_W-1:0];
    o.evicted = evict_flag;
    return o;
  endfunction

  // Mostly reused tags in a few sets so that hits and evictions are frequent.
  function automatic logic [ADDRESS_W-1:0] pick_address(input bit narrow);
    longint unsigned tag, set_idx, offset;
    logic [63:0]     raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 2) return raw[ADDRESS_W-1:0];
    tag = tag_pool[$urandom_range(0, 7)];
    if (narrow) begin
      set_idx = 64'($urandom_range(0, 1));
    end else if ($urandom_range(0, 1) == 0) begin
      set_idx = 64'($urandom_range(0, 7));
    end else begin
      set_idx = 64'($urandom_range(0, N_SETS - 1));
    end
    offset = 64'($urandom_range(0, LINE_BYTES - 1));
    return ADDRESS_W'((tag * N_SETS + set_idx) * LINE_BYTES + offset);
  endfunction

  // Offers one word after a random gap and records its expected result once accepted.
  task automatic offer(input logic [ADDRESS_W-1:0] a, input bit typed, input outcome_t want);
    int       gap;
    outcome_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      access_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    access_bus.valid   <= 1'b1;
    access_bus.address <= a;
    do @(posedge clk); while (!access_bus.ready);
    predicted = lookup_and_age(a);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  task automatic check_result();
    outcome_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result word: hit %0d way %0d evicted %0d",
             result_bus.hit, result_bus.way, result_bus.evicted);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      if (result_bus.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, result_bus.hit);
        mismatch_count++;
      end
      if (result_bus.way !== want.way) begin
        $error("way: expected %0d, got %0d", want.way, result_bus.way);
        mismatch_count++;
      end
      if (result_bus.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, result_bus.evicted);
        mismatch_count++;
      end
    end
  endtask

  // Result side: random stalls, one long hold-off on request, a check per word.
  initial begin
    int stall;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          result_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      check_result();
    end
  end

  // Access side: reset, directed words, random words, then drain and report.
  initial begin
    logic [63:0] raw;
    rst                <= 1'b1;
    access_bus.valid   <= 1'b0;
    access_bus.address <= '0;
    tag_pool[0] = '0;
    tag_pool[1] = TAG_MAX;
    for (int i = 2; i < 8; i++) begin
      raw = {$urandom, $urandom};
      tag_pool[i] = raw & TAG_MAX;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].address, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet = (i < 100) || (i >= 400 && i < 500);
      // Stop offering once and let every outstanding result come back.
      if (i == DRAIN_AT) begin
        access_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      // Back-to-back words while the result side holds off fill the block up.
      if (i == HOLD_AT) hold_request = 1'b1;
      offer(pick_address(i >= 550 && i < 650), 1'b0, '0);
    end
    access_bus.valid <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sac_pkg.sv
hdl/sac_if.sv
hdl/sac_ram.sv
hdl/sac_fifo.sv
hdl/sac_front.sv
hdl/sac_back.sv
hdl/set_assoc_cache_lru.sv
sim/set_assoc_cache_lru_tb.sv
